// ===== sv/wei_pkg.sv =====
// Shared types and constants for the windowed error integrator.
package wei_pkg;

  // Field widths
  localparam int GOAL_W = 16;
  localparam int DERR_W = 16;
  localparam int AERR_W = 15;
  localparam int DSUM_W = 21;
  localparam int ASUM_W = 19;
  localparam int THR_W  = 16;
  localparam int LIM_W  = 20;
  localparam int TSQ_W  = 2 * THR_W;
  localparam int SQ_W   = 2 * (GOAL_W + 1);
  localparam int D2_W   = SQ_W + 1;

  // Distance accumulator: sum plus one guard bit
  localparam int ACC_W  = DSUM_W + 1;

  // Stream word widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  // Ring window (entries held: RING_DEPTH - 1)
  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_MAX    = RING_DEPTH - 1;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Configuration
  localparam int CFG_IDX_W = 2;
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(50);
  localparam logic [LIM_W-1:0] LIMIT_RST     = LIM_W'(1000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOAL_THRESHOLD = 2'd0,
    CFG_SUM_LIMIT      = 2'd1
  } cfg_reg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic                     cleared;
    logic [DERR_W-1:0]        derr;
    logic signed [AERR_W-1:0] aerr;
  } wei_item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } wei_qstat_t;

endpackage

// ===== sv/wei_front.sv =====
// Front end: accepts words, squares the goal move and flags history clears.
module wei_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [wei_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [wei_pkg::THR_W-1:0]    threshold,
  input  wei_pkg::wei_qstat_t          qstat,
  output logic                         q_push,
  output wei_pkg::wei_item_t           q_item
);
  import wei_pkg::*;

  logic signed [GOAL_W-1:0] gx, gy;
  logic signed [GOAL_W:0]   dx, dy;
  logic signed [SQ_W-1:0]   sqx_s, sqy_s;
  logic                     in_acc;
  logic [D2_W-1:0]          d2;

  logic signed [GOAL_W-1:0] last_x_r, last_y_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic [DERR_W-1:0]        derr_r;
  logic signed [AERR_W-1:0] aerr_r;
  logic                     s1_valid_r, s1_valid_nxt;
  logic [TSQ_W-1:0]         tsq_r;

  // Unpack and square the goal displacement
  assign gx    = $signed(in_tdata[15:0]);
  assign gy    = $signed(in_tdata[31:16]);
  assign dx    = {gx[GOAL_W-1], gx} - {last_x_r[GOAL_W-1], last_x_r};
  assign dy    = {gy[GOAL_W-1], gy} - {last_y_r[GOAL_W-1], last_y_r};
  assign sqx_s = dx * dx;
  assign sqy_s = dy * dy;

  // Handshake: stage holds while the queue is full
  assign q_push    = s1_valid_r && !qstat.full;
  assign in_tready = !s1_valid_r || !qstat.full;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Squared distance compare
  assign d2 = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign q_item.cleared = d2 > D2_W'(tsq_r);
  assign q_item.derr    = derr_r;
  assign q_item.aerr    = aerr_r;

  // Control and goal history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      last_x_r   <= '0;
      last_y_r   <= '0;
      tsq_r      <= TSQ_W'(THRESHOLD_RST) * TSQ_W'(THRESHOLD_RST);
    end else begin
      s1_valid_r <= s1_valid_nxt;
      tsq_r      <= TSQ_W'(threshold) * TSQ_W'(threshold);
      if (in_acc) begin
        last_x_r <= gx;
        last_y_r <= gy;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sqx_r  <= $unsigned(sqx_s);
      sqy_r  <= $unsigned(sqy_s);
      derr_r <= in_tdata[47:32];
      aerr_r <= $signed(in_tdata[62:48]);
    end
  end

  // A blocked stage keeps its word
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && qstat.full |=> s1_valid_r && $stable(sqx_r) && $stable(derr_r))
    else $error("front stage lost a word while the queue was full");

  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && qstat.full |-> !in_acc)
    else $error("front accepted a word with its stage blocked");

  a_goal_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> last_x_r == $past(gx) && last_y_r == $past(gy))
    else $error("previous goal not updated on accept");

endmodule

// ===== sv/wei_queue.sv =====
// Short queue of classified words between front and back.
module wei_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wei_pkg::wei_item_t  push_item,
  input  logic                pop,
  output wei_pkg::wei_item_t  pop_item,
  output wei_pkg::wei_qstat_t qstat
);
  import wei_pkg::*;

  wei_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign qstat.full  = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign qstat.empty = cnt_r == '0;
  assign pop_item    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("queue read while empty");

  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue level out of range");

endmodule

// ===== sv/wei_back.sv =====
// Back end: window rings, running sums, clamp and result register.
module wei_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wei_pkg::wei_item_t            q_item,
  input  wei_pkg::wei_qstat_t           qstat,
  output logic                          q_pop,
  input  logic [wei_pkg::LIM_W-1:0]     limit,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wei_pkg::OUT_DATA_W-1:0] out_tdata,  // distance_sum, angle_sum
  output logic                          out_tuser   // was_cleared
);
  import wei_pkg::*;

  logic [DERR_W-1:0]        dring_r [RING_DEPTH];
  logic signed [AERR_W-1:0] aring_r [RING_DEPTH];

  logic [RING_AW-1:0]       head_r, head_nxt, head_eff, slot;
  logic [RING_AW-1:0]       cnt_r, cnt_nxt, cnt_eff;
  logic [RING_AW:0]         slot_sum;
  logic signed [DSUM_W-1:0] dsum_r, dsum_nxt, dsum_base;
  logic signed [ASUM_W-1:0] asum_r, asum_nxt, asum_base, a_old;
  logic signed [ACC_W-1:0]  d_acc, d_old, lim_s;
  logic                     win_full;
  logic                     out_valid_r, out_valid_nxt;
  logic                     cleared_r;

  assign q_pop = !qstat.empty && (!out_valid_r || out_tready);

  // A goal move restarts the window from empty
  assign head_eff  = q_item.cleared ? '0 : head_r;
  assign cnt_eff   = q_item.cleared ? '0 : cnt_r;
  assign dsum_base = q_item.cleared ? '0 : dsum_r;
  assign asum_base = q_item.cleared ? '0 : asum_r;
  assign win_full  = cnt_eff == RING_AW'(CNT_MAX);

  // Write slot behind the oldest entry
  always_comb begin
    slot_sum = {1'b0, head_eff} + {1'b0, cnt_eff};
    if (slot_sum >= (RING_AW+1)'(RING_DEPTH)) begin
      slot_sum = slot_sum - (RING_AW+1)'(RING_DEPTH);
    end
    slot = slot_sum[RING_AW-1:0];
  end

  // Oldest entry leaves once the window is full
  assign d_old = win_full ? ACC_W'(dring_r[head_eff]) : '0;
  assign a_old = win_full ? ASUM_W'(aring_r[head_eff]) : '0;

  // Distance sum with symmetric clamp
  assign lim_s = $signed({2'b00, limit});
  assign d_acc = ACC_W'(dsum_base) + $signed({6'd0, q_item.derr}) - d_old;

  always_comb begin
    if (d_acc < -lim_s) begin
      dsum_nxt = DSUM_W'(-lim_s);
    end else if (d_acc > lim_s) begin
      dsum_nxt = DSUM_W'(lim_s);
    end else begin
      dsum_nxt = DSUM_W'(d_acc);
    end
  end

  // Angle sum wraps in its own width
  assign asum_nxt = asum_base + ASUM_W'(q_item.aerr) - a_old;

  always_comb begin
    head_nxt = head_eff;
    cnt_nxt  = cnt_eff + 1'b1;
    if (win_full) begin
      head_nxt = (head_eff == RING_AW'(RING_DEPTH - 1)) ? '0 : head_eff + 1'b1;
      cnt_nxt  = cnt_eff;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Window state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      dsum_r      <= '0;
      asum_r      <= '0;
      out_valid_r <= 1'b0;
      cleared_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        head_r    <= head_nxt;
        cnt_r     <= cnt_nxt;
        dsum_r    <= dsum_nxt;
        asum_r    <= asum_nxt;
        cleared_r <= q_item.cleared;
      end
    end
  end

  // Ring storage
  always_ff @(posedge clk) begin
    if (q_pop) begin
      dring_r[slot] <= q_item.derr;
      aring_r[slot] <= q_item.aerr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {asum_r, dsum_r};
  assign out_tuser  = cleared_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RING_AW'(CNT_MAX))
    else $error("window count beyond its limit");

  a_clear_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_item.cleared |=> cnt_r == RING_AW'(1) && head_r == '0)
    else $error("window not restarted after a goal move");

  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (ACC_W'(dsum_r) <= $past(lim_s)) && (ACC_W'(dsum_r) >= -$past(lim_s)))
    else $error("distance sum outside its limit");

endmodule

// ===== sv/windowed_error_integrator.sv =====
// Top level of the windowed error integrator: configuration and front/queue/back.
//
//  channel  direction  handshake          payload
//  in_      slave      in_tvalid/tready   tdata: goal_x, goal_y, dist_err, ang_err
//  out_     master     out_tvalid/tready  tdata: distance_sum, angle_sum; tuser: was_cleared
//  cfg_     slave      cfg_valid/ready    cfg_index, cfg_data (cfg_ready always high)
//
//  One word per cycle sustained while out_tready stays high; out_tvalid rises after a word's accept
//  (square stage, compare into the four-entry queue, window update into the result register).
//  The back end reads the oldest ring entry, adds and subtracts combinationally for each word.
//  Reset (rst_n low, synchronous) empties the windows, zeros sums and previous goal.
//  An output stall fills the queue, then the front stage, then drops in_tready.
//  A new threshold takes effect once it has passed threshold_r and the squared-threshold register.
module windowed_error_integrator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // goal_x[15:0], goal_y[31:16], dist_err[47:32], ang_err[62:48], zero[63]
  input  logic [wei_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // distance_sum[20:0], angle_sum[39:21]
  output logic [wei_pkg::OUT_DATA_W-1:0]     out_tdata,
  // was_cleared[0]
  output logic                               out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wei_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wei_pkg::LIM_W-1:0]          cfg_data
);
  import wei_pkg::*;

  logic [THR_W-1:0] threshold_r;
  logic [LIM_W-1:0] limit_r;
  logic             q_push, q_pop;
  wei_item_t        push_item, pop_item;
  wei_qstat_t       qstat;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      limit_r     <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GOAL_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
        CFG_SUM_LIMIT:      limit_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  wei_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .threshold (threshold_r),
    .qstat     (qstat),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  wei_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  wei_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (pop_item),
    .qstat      (qstat),
    .q_pop      (q_pop),
    .limit      (limit_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
